>>> rtl/mtt_pkg.sv
// Shared types and constants of the multi-channel timer table.
// Used by the channel interfaces, controller, datapath, top level and checker.
package mtt_pkg;

  // field widths fixed by the item format
  localparam int unsigned SlotSpace = 32;
  localparam int unsigned FuncW     = 3;
  localparam int unsigned SlotW     = 5;
  localparam int unsigned PayW      = 8;
  localparam int unsigned QueueW    = 2;
  localparam int unsigned TimeW     = 32;

  // result kinds
  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // command codes
  typedef enum logic [FuncW-1:0] {
    FN_ALLOC   = 3'd0,
    FN_FREE    = 3'd1,
    FN_INIT    = 3'd2,
    FN_SETTIME = 3'd3,
    FN_TICK    = 3'd4
  } func_e;

  // slot status
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_ARMED = 2'd2
  } slot_st_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_TICK,
    S_FLUSH
  } ctrl_state_e;

  // one input item
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [SlotW-1:0]  slot;
    logic [PayW-1:0]   payload;
    logic [QueueW-1:0] dest_queue;
    logic [TimeW-1:0]  delay;
  } req_t;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [SlotW-1:0]  slot_out;
    logic              alloc_ok;
    logic [PayW-1:0]   payload_out;
    logic [QueueW-1:0] queue_out;
    logic              last;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic do_free;
    logic do_init;
    logic do_settime;
    logic do_tick;
    logic scan_clr;
    logic advance;
    logic mark_alloc;
    logic capture;
    logic push_pend;
    logic push_last;
    logic emit_alloc;
    logic alloc_ok;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic free_hit;
    logic exp_hit;
    logic at_end;
    logic out_free;
    logic pend_valid;
  } stat_t;

endpackage

>>> rtl/mtt_in_if.sv
// Command channel of the timer table: valid/ready plus one command item.
// Depends on mtt_pkg for the field widths.
interface mtt_in_if;
  import mtt_pkg::*;

  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [SlotW-1:0]  slot;
  logic [PayW-1:0]   payload;
  logic [QueueW-1:0] dest_queue;
  logic [TimeW-1:0]  delay;

  modport source (output valid, func, slot, payload, dest_queue, delay, input ready);
  modport sink   (input valid, func, slot, payload, dest_queue, delay, output ready);
endinterface

>>> rtl/mtt_out_if.sv
// Result channel of the timer table: valid/ready plus one result item.
// Depends on mtt_pkg for the field widths.
interface mtt_out_if;
  import mtt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SlotW-1:0]  slot_out;
  logic              alloc_ok;
  logic [PayW-1:0]   payload_out;
  logic [QueueW-1:0] queue_out;
  logic              last;

  modport source (output valid, kind, slot_out, alloc_ok, payload_out, queue_out, last,
                  input ready);
  modport sink   (input valid, kind, slot_out, alloc_ok, payload_out, queue_out, last,
                  output ready);
endinterface

>>> rtl/mtt_ctrl.sv
// Controller of the timer table: command decode and slot scan sequencing.
// Depends on mtt_pkg; drives the datapath through cmd_t and reads stat_t.
module mtt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mtt_pkg::FuncW-1:0]  in_func_i,
  output logic                       in_ready_o,
  input  mtt_pkg::stat_t             stat_i,
  output mtt_pkg::cmd_t              cmd_o
);
  import mtt_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (func_e'(in_func_i))
            FN_ALLOC: begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_ALLOC;
            end
            FN_FREE:    cmd_o.do_free    = 1'b1;
            FN_INIT:    cmd_o.do_init    = 1'b1;
            FN_SETTIME: cmd_o.do_settime = 1'b1;
            FN_TICK: begin
              cmd_o.do_tick  = 1'b1;
              cmd_o.scan_clr = 1'b1;
              state_d        = S_TICK;
            end
            default: ;
          endcase
        end
      end

      // look for the lowest free slot, answer once the output register is free
      S_ALLOC: begin
        if (stat_i.free_hit) begin
          if (stat_i.out_free) begin
            cmd_o.emit_alloc = 1'b1;
            cmd_o.alloc_ok   = 1'b1;
            cmd_o.mark_alloc = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (stat_i.at_end) begin
          if (stat_i.out_free) begin
            cmd_o.emit_alloc = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end

      // expired slots go through a one-deep holding stage so the final one gets last
      S_TICK: begin
        if (stat_i.exp_hit) begin
          if (!stat_i.pend_valid || stat_i.out_free) begin
            cmd_o.push_pend  = stat_i.pend_valid;
            cmd_o.capture    = 1'b1;
            cmd_o.mark_alloc = 1'b1;
            if (stat_i.at_end) begin
              state_d = S_FLUSH;
            end else begin
              cmd_o.advance = 1'b1;
            end
          end
        end else if (stat_i.at_end) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end

      // hand over the held expiry as the final result of the tick
      S_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.push_pend = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/mtt_datapath.sv
// Datapath of the timer table: slot status, deadline and data stores,
// tick counter, scan index, expiry holding stage and output register. Depends on mtt_pkg.
module mtt_datapath #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtt_pkg::req_t  req_i,
  input  mtt_pkg::cmd_t  cmd_i,
  output mtt_pkg::stat_t stat_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output mtt_pkg::res_t  out_data_o
);
  import mtt_pkg::*;

  localparam int unsigned TableSize = (NUM_TIMERS < SlotSpace) ? NUM_TIMERS : SlotSpace;
  localparam int unsigned IdxW      = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(TableSize - 1);
  localparam logic [SlotW:0]   TableExt = (SlotW + 1)'(TableSize);

  slot_st_e          status_q   [TableSize];
  logic [TimeW-1:0]  deadline_q [TableSize];
  logic [PayW-1:0]   payload_q  [TableSize];
  logic [QueueW-1:0] queue_q    [TableSize];

  logic [TimeW-1:0]  tick_q;
  logic [IdxW-1:0]   idx_q;
  logic              pend_valid_q;
  res_t              pend_q;
  logic              out_valid_q;
  res_t              out_q;

  logic              slot_ok;
  logic [IdxW-1:0]   slot_idx;
  logic              out_free;

  // addressed slot must lie inside the table
  assign slot_ok  = {1'b0, req_i.slot} < TableExt;
  assign slot_idx = req_i.slot[IdxW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  // slot status, cleared to free at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(TableSize); i++) begin
        status_q[i] <= ST_FREE;
      end
    end else begin
      if (cmd_i.do_free && slot_ok) begin
        status_q[slot_idx] <= ST_FREE;
      end
      if (cmd_i.do_settime && slot_ok) begin
        status_q[slot_idx] <= ST_ARMED;
      end
      if (cmd_i.mark_alloc) begin
        status_q[idx_q] <= ST_ALLOC;
      end
    end
  end

  // deadline and data stores, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_settime && slot_ok) begin
      deadline_q[slot_idx] <= req_i.delay + tick_q;
    end
    if (cmd_i.do_init && slot_ok) begin
      payload_q[slot_idx] <= req_i.payload;
      queue_q[slot_idx]   <= req_i.dest_queue;
    end
  end

  // tick counter and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.do_tick) begin
        tick_q <= tick_q + 1'b1;
      end
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // scan status for the slot under the index
  assign stat_o.free_hit   = (status_q[idx_q] == ST_FREE);
  assign stat_o.exp_hit    = (status_q[idx_q] == ST_ARMED) && (deadline_q[idx_q] <= tick_q);
  assign stat_o.at_end     = (idx_q == LastIdx);
  assign stat_o.out_free   = out_free;
  assign stat_o.pend_valid = pend_valid_q;

  // expiry holding stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.push_pend) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pend_q.kind        <= KIND_EXPIRY;
      pend_q.slot_out    <= SlotW'(idx_q);
      pend_q.alloc_ok    <= 1'b0;
      pend_q.payload_out <= payload_q[idx_q];
      pend_q.queue_out   <= queue_q[idx_q];
      pend_q.last        <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_alloc || cmd_i.push_pend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_alloc) begin
      out_q.kind        <= KIND_ALLOC;
      out_q.slot_out    <= cmd_i.alloc_ok ? SlotW'(idx_q) : '0;
      out_q.alloc_ok    <= cmd_i.alloc_ok;
      out_q.payload_out <= '0;
      out_q.queue_out   <= '0;
      out_q.last        <= 1'b1;
    end else if (cmd_i.push_pend) begin
      out_q.kind        <= pend_q.kind;
      out_q.slot_out    <= pend_q.slot_out;
      out_q.alloc_ok    <= pend_q.alloc_ok;
      out_q.payload_out <= pend_q.payload_out;
      out_q.queue_out   <= pend_q.queue_out;
      out_q.last        <= cmd_i.push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/multi_timer_table.sv
// Multi-channel timer table: top level joining controller and datapath.
// Depends on mtt_pkg, mtt_in_if, mtt_out_if, mtt_ctrl and mtt_datapath.
//
// Commands arrive on in_i (valid/ready), one transfer per command; results leave
// on out_o (valid/ready) from an output register.
// Free, init and settime complete in the cycle of their transfer; the next
// command may follow in the following cycle.
// Alloc scans slots from index 0, one slot a cycle, and answers from the first
// free slot, or with a failure if none of the N = min(NUM_TIMERS, 32) is free.
// Tick bumps the counter and scans all N slots, one a cycle while no expiry waits
// on the output register, then hands over the final held expiry. Each expiry is
// held in a one-deep stage until the next is found, so the final one carries last.
// While a scan runs, in_i.ready is low; a stalled receiver holds the output
// register, and the scan waits on the next result that needs it.
// Reset (rst_ni low, asynchronous) frees every slot, zeroes the tick count and
// empties the output; stored data and deadlines keep no reset value.
module multi_timer_table #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtt_in_if.sink     in_i,
  mtt_out_if.source  out_o
);
  import mtt_pkg::*;

  req_t  req;
  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  res_valid;

  // gather the command fields
  assign req.func       = in_i.func;
  assign req.slot       = in_i.slot;
  assign req.payload    = in_i.payload;
  assign req.dest_queue = in_i.dest_queue;
  assign req.delay      = in_i.delay;

  mtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtt_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (res_valid),
    .out_data_o  (res)
  );

  // drive the result channel
  assign out_o.valid       = res_valid;
  assign out_o.kind        = res.kind;
  assign out_o.slot_out    = res.slot_out;
  assign out_o.alloc_ok    = res.alloc_ok;
  assign out_o.payload_out = res.payload_out;
  assign out_o.queue_out   = res.queue_out;
  assign out_o.last        = res.last;

endmodule

>>> rtl/mtt_checker.sv
// Port-level checks on the timer table, bound to multi_timer_table.
// Depends on mtt_pkg for the command and result codes.
module mtt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [mtt_pkg::FuncW-1:0]  in_func_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_kind_i,
  input logic [mtt_pkg::SlotW-1:0]  out_slot_i,
  input logic                       out_ok_i,
  input logic [mtt_pkg::PayW-1:0]   out_pay_i,
  input logic [mtt_pkg::QueueW-1:0] out_queue_i,
  input logic                       out_last_i
);
  import mtt_pkg::*;

  // stalled result holds its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i) &&
      $stable(out_kind_i) && $stable(out_pay_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // an alloc answer is a single, final result with no data
  a_alloc_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_ALLOC |->
      out_last_i && out_pay_i == '0 && out_queue_i == '0)
    else $error("alloc answer fields wrong");

  // failed alloc reports slot zero
  a_ok_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i && out_kind_i == KIND_ALLOC |-> out_slot_i == '0)
    else $error("failed alloc with nonzero slot");

  // an accepted alloc starts a scan, so no command is taken next cycle
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == FN_ALLOC |=> !in_ready_i)
    else $error("command taken during alloc scan");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_slot_i  (out_o.slot_out),
  .out_ok_i    (out_o.alloc_ok),
  .out_pay_i   (out_o.payload_out),
  .out_queue_i (out_o.queue_out),
  .out_last_i  (out_o.last)
);
